// ===== sv/lru_pkg.sv =====
// Shared constants and controller/datapath command and status types
// for the LRU page replacement block. No dependencies.
`timescale 1ns / 1ps

package lru_pkg;

    localparam int NUM_PROCESSES     = 20;
    localparam int PAGES_PER_PROCESS = 20;
    localparam int PAGE_SIZE         = 128;
    localparam int STAMP_WIDTH       = 32;

    // Field widths of the item channels
    localparam int PROC_W = 5;
    localparam int PC_W   = 12;
    localparam int MASK_W = 20;
    localparam int PAGE_W = 5;

    localparam int PAGE_SHIFT = $clog2(PAGE_SIZE);
    localparam int MEM_DEPTH  = NUM_PROCESSES * PAGES_PER_PROCESS;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int CNT_W      = $clog2(PAGES_PER_PROCESS + 1);
    localparam int IDX_W      = $clog2(PAGES_PER_PROCESS);

    localparam logic [STAMP_WIDTH-1:0] STAMP_MAX = {STAMP_WIDTH{1'b1}};

    typedef struct packed {
        logic clear_en;
        logic accept;
        logic scan_step;
        logic load_out;
    } lru_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic need_scan;
        logic scan_done;
        logic out_free;
    } lru_sts_t;

endpackage

// ===== sv/lru_if.sv =====
// Request and response item channels of the LRU page replacement block.
// Depends on lru_pkg for field widths.
`timescale 1ns / 1ps

interface lru_req_if;
    logic                        valid;
    logic                        ready;
    logic [lru_pkg::PROC_W-1:0]  process;
    logic                        active;
    logic [lru_pkg::PC_W-1:0]    pc;
    logic [lru_pkg::MASK_W-1:0]  resident_mask;
    logic                        frame_free;

    modport source (output valid, process, active, pc, resident_mask, frame_free,
                    input ready);
    modport sink   (input valid, process, active, pc, resident_mask, frame_free,
                    output ready);
endinterface

interface lru_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        fault;
    logic [lru_pkg::PAGE_W-1:0]  page_in_page;
    logic                        evict_valid;
    logic [lru_pkg::PAGE_W-1:0]  victim_page;

    modport source (output valid, fault, page_in_page, evict_valid, victim_page,
                    input ready);
    modport sink   (input valid, fault, page_in_page, evict_valid, victim_page,
                    output ready);
endinterface

// ===== sv/lru_ctrl.sv =====
// Controller state machine: clearing pass, accept, stamp scan, result hand-off.
// Depends on lru_pkg.
`timescale 1ns / 1ps

module lru_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lru_pkg::lru_sts_t sts,
    output lru_pkg::lru_cmd_t cmd
);
    import lru_pkg::*;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd.clear_en  = (state_reg == ST_CLEAR);
        cmd.accept    = in_ready && in_valid;
        cmd.scan_step = (state_reg == ST_SCAN);
        cmd.load_out  = (state_reg == ST_FINISH) && sts.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = sts.need_scan ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/lru_dpath.sv =====
// Datapath: stamp memory, tick counter, oldest-stamp search and result register.
// Depends on lru_pkg; driven by lru_ctrl commands.
`timescale 1ns / 1ps

module lru_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lru_pkg::lru_cmd_t           cmd,
    output lru_pkg::lru_sts_t           sts,
    input  logic [lru_pkg::PROC_W-1:0]  process,
    input  logic                        active,
    input  logic [lru_pkg::PC_W-1:0]    pc,
    input  logic [lru_pkg::MASK_W-1:0]  resident_mask,
    input  logic                        frame_free,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        fault,
    output logic [lru_pkg::PAGE_W-1:0]  page_in_page,
    output logic                        evict_valid,
    output logic [lru_pkg::PAGE_W-1:0]  victim_page
);
    import lru_pkg::*;

    logic [STAMP_WIDTH-1:0] mem [MEM_DEPTH];

    logic [PC_W-1:0]        page_wide;
    logic [PAGE_W-1:0]      page_cur;
    logic [ADDR_W-1:0]      base_cur;
    logic                   eff_cur;
    logic                   fault_cur;

    logic [STAMP_WIDTH-1:0] tick_reg;
    logic [ADDR_W-1:0]      clr_cnt_reg;
    logic [ADDR_W-1:0]      base_reg;
    logic [PAGE_W-1:0]      page_reg;
    logic [MASK_W-1:0]      mask_reg;
    logic                   fault_reg;
    logic                   scan_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   rd_valid_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [STAMP_WIDTH-1:0] rd_data_reg;
    logic                   found_reg;
    logic [STAMP_WIDTH-1:0] best_reg;
    logic [PAGE_W-1:0]      victim_reg;

    logic                   out_valid_reg;
    logic                   fault_out_reg;
    logic [PAGE_W-1:0]      pin_out_reg;
    logic                   evict_out_reg;
    logic [PAGE_W-1:0]      victim_out_reg;

    logic                   issue;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [STAMP_WIDTH-1:0] wr_data;
    logic                   take;

    // Decode the incoming item
    assign page_wide = pc >> PAGE_SHIFT;
    assign page_cur  = page_wide[PAGE_W-1:0];
    assign base_cur  = ADDR_W'(process) * ADDR_W'(PAGES_PER_PROCESS);
    assign eff_cur   = active && (process < PROC_W'(NUM_PROCESSES))
                       && (page_wide < PC_W'(PAGES_PER_PROCESS));
    assign fault_cur = eff_cur && !(|((resident_mask >> page_cur) & MASK_W'(1)));

    assign issue   = cmd.scan_step && (cnt_reg < CNT_W'(PAGES_PER_PROCESS));
    assign rd_addr = base_reg + ADDR_W'(cnt_reg);

    assign wr_en   = cmd.clear_en || (cmd.accept && eff_cur);
    assign wr_addr = cmd.clear_en ? clr_cnt_reg : (base_cur + ADDR_W'(page_cur));
    assign wr_data = cmd.clear_en ? '0 : tick_reg;

    assign take = out_valid_reg && out_ready;

    always_comb
    begin
        sts.clear_done = (clr_cnt_reg == ADDR_W'(MEM_DEPTH - 1));
        sts.need_scan  = fault_cur && !frame_free;
        sts.scan_done  = rd_valid_reg && (rd_idx_reg == IDX_W'(PAGES_PER_PROCESS - 1));
        sts.out_free   = !out_valid_reg || out_ready;
    end

    // Stamp memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (issue)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= STAMP_WIDTH'(1);
            clr_cnt_reg  <= '0;
            rd_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (cmd.clear_en)
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            if (cmd.accept)
            begin
                if (tick_reg != STAMP_MAX)
                    tick_reg <= tick_reg + STAMP_WIDTH'(1);
                cnt_reg <= '0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            rd_valid_reg <= issue;
        end
    end

    // Captured item and running oldest-stamp search
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            base_reg   <= base_cur;
            page_reg   <= page_cur;
            mask_reg   <= resident_mask;
            fault_reg  <= fault_cur;
            scan_reg   <= fault_cur && !frame_free;
            found_reg  <= 1'b0;
            best_reg   <= '0;
            victim_reg <= page_cur;
        end
        else if (rd_valid_reg && mask_reg[rd_idx_reg]
                 && (!found_reg || (rd_data_reg < best_reg)))
        begin
            found_reg  <= 1'b1;
            best_reg   <= rd_data_reg;
            victim_reg <= PAGE_W'(rd_idx_reg);
        end
        if (issue)
            rd_idx_reg <= cnt_reg[IDX_W-1:0];
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (take)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            fault_out_reg  <= fault_reg;
            pin_out_reg    <= fault_reg ? page_reg : '0;
            evict_out_reg  <= scan_reg;
            victim_out_reg <= scan_reg ? victim_reg : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign fault        = fault_out_reg;
    assign page_in_page = pin_out_reg;
    assign evict_valid  = evict_out_reg;
    assign victim_page  = victim_out_reg;

endmodule

// ===== sv/lru_page_replacement_top.sv =====
// LRU page replacement: how the block is used.
// req carries one step of one process (process, active, pc, resident_mask,
// frame_free); rsp returns exactly one result item per request item
// (fault, page_in_page, evict_valid, victim_page). Both channels move an
// item on a clock edge with valid and ready high.
// An item that needs no victim goes from acceptance to the ST_FINISH state,
// which loads the result register once it is free, and then back to ST_IDLE
// to take the next item. A fault with no free frame first passes through
// ST_SCAN, which walks the process's 20 stamps on the single registered read
// port of the stamp memory, one stamp per cycle, and waits for the last
// read to return before ST_FINISH loads the result.
// One item is worked on at a time; the next is taken as soon as its
// predecessor's result sits in the output register.
// Reset: rst_n clears the tick to one and starts a clearing pass that writes
// zero to all 400 stamps, one per cycle; req.ready stays low until the pass
// is over. When the receiver stalls the result holds in the output register;
// one further item is accepted and processed, then held until rsp drains.
// Depends on lru_pkg, lru_if, lru_ctrl and lru_dpath.
`timescale 1ns / 1ps

module lru_page_replacement_top (
    input  logic          clk,
    input  logic          rst_n,
    lru_req_if.sink       req,
    lru_rsp_if.source     rsp
);
    import lru_pkg::*;

    lru_cmd_t cmd;
    lru_sts_t sts;

    // Sequencing: clear, accept, scan, hand off
    lru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Stamps, tick, victim search and result register
    lru_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .process       (req.process),
        .active        (req.active),
        .pc            (req.pc),
        .resident_mask (req.resident_mask),
        .frame_free    (req.frame_free),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .fault         (rsp.fault),
        .page_in_page  (rsp.page_in_page),
        .evict_valid   (rsp.evict_valid),
        .victim_page   (rsp.victim_page)
    );

endmodule

// ===== sv/lru_chk.sv =====
// Port-level checker for the LRU page replacement block, bound to the top.
// Depends on lru_pkg and lru_page_replacement_top.
`timescale 1ns / 1ps

module lru_chk (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_ready,
    input  logic                        rsp_valid,
    input  logic                        rsp_ready,
    input  logic                        fault,
    input  logic [lru_pkg::PAGE_W-1:0]  page_in_page,
    input  logic                        evict_valid,
    input  logic [lru_pkg::PAGE_W-1:0]  victim_page
);
    import lru_pkg::*;

    // A victim is only named on a fault
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && evict_valid |-> fault)
        else $error("eviction without fault");

    // No fault leaves every other field at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !fault |-> (page_in_page == '0) && !evict_valid
                                && (victim_page == '0))
        else $error("non-fault result carries data");

    // Pages named are within the process's page range
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && fault |-> (page_in_page < PAGE_W'(PAGES_PER_PROCESS))
                               && (victim_page < PAGE_W'(PAGES_PER_PROCESS)))
        else $error("page index out of range");

    // One item in flight: ready drops after every acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second item accepted back to back");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(fault)
            && $stable(page_in_page) && $stable(evict_valid) && $stable(victim_page))
        else $error("stalled result changed");

endmodule

bind lru_page_replacement_top lru_chk u_lru_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .fault        (rsp.fault),
    .page_in_page (rsp.page_in_page),
    .evict_valid  (rsp.evict_valid),
    .victim_page  (rsp.victim_page)
);
